// ===== src/nns_pkg.sv =====
// Shared constants, types and helpers for the nearest-neighbor scale addresser.
// Used by the stream interfaces, the step divider and the top level.
`default_nettype none

package nns_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int DIM_W     = 13;
  localparam int POS_W     = 12;
  localparam int ACC_W     = 28;
  localparam int FRAC_W    = 16;
  localparam int DIV_CNT_W = $clog2(ACC_W);
  localparam int REM_W     = POS_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = CFG_IDX_W'(3);

  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] numer;
    logic [DIM_W-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

  // clamp(src) * 65535 as (src << 16) - src
  function automatic logic [ACC_W-1:0] step_numer(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0]   c;
    logic [ACC_W:0]     full;
    c    = clamp_dim(v);
    full = {c, {FRAC_W{1'b0}}} - (ACC_W+1)'(c);
    return full[ACC_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/nns_if.sv =====
// Valid/ready stream interfaces for the scale addresser input and output beats.
// Depends on nns_pkg for field widths.
`default_nettype none

interface nns_in_if;
  logic valid;
  logic ready;
  logic start_req;

  modport source (output valid, output start_req, input ready);
  modport sink (input valid, input start_req, output ready);
endinterface

interface nns_out_if;
  logic                     valid;
  logic                     ready;
  logic [nns_pkg::POS_W-1:0] src_col;
  logic [nns_pkg::POS_W-1:0] src_row;
  logic [nns_pkg::POS_W-1:0] dst_col;
  logic [nns_pkg::POS_W-1:0] dst_row;
  logic                     end_of_line;
  logic                     end_of_frame;

  modport source (output valid, output src_col, output src_row, output dst_col,
                  output dst_row, output end_of_line, output end_of_frame, input ready);
  modport sink (input valid, input src_col, input src_row, input dst_col,
                input dst_row, input end_of_line, input end_of_frame, output ready);
endinterface

`default_nettype wire

// ===== src/nns_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle, for the 12.16 steps.
// Depends on nns_pkg for widths and the request/response structs.
`default_nettype none

module nns_divider (
  input  logic              clk,
  input  logic              rst,
  input  nns_pkg::div_req_t req,
  output nns_pkg::div_rsp_t rsp
);

  logic                             busy;
  logic                             done;
  logic [nns_pkg::DIV_CNT_W-1:0]    cnt;
  logic [nns_pkg::ACC_W-1:0]        quo;
  logic [nns_pkg::REM_W-1:0]        rem;
  logic [nns_pkg::DIM_W-1:0]        den;

  logic [nns_pkg::REM_W:0]          rem_shift;
  logic [nns_pkg::REM_W+1:0]        diff;
  logic                             q_bit;
  logic [nns_pkg::REM_W-1:0]        rem_next;

  assign rem_shift = {rem, quo[nns_pkg::ACC_W-1]};
  assign diff      = {1'b0, rem_shift} - {1'b0, den};
  assign q_bit     = ~diff[nns_pkg::REM_W+1];
  assign rem_next  = q_bit ? diff[nns_pkg::REM_W-1:0] : rem_shift[nns_pkg::REM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= req.numer;
        rem  <= '0;
        den  <= req.denom;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[nns_pkg::ACC_W-2:0], q_bit};
        cnt <= cnt + nns_pkg::DIV_CNT_W'(1);
        if (cnt == nns_pkg::DIV_CNT_W'(nns_pkg::ACC_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

// ===== src/nearest_neighbor_scale_addresser.sv =====
// Nearest-neighbor scale addresser: emits one source/destination pixel position per
// item in raster order. An item with start_req first waits for the shared 28-step divider,
// which computes the horizontal and then the vertical 12.16 step. Output beats sit in a
// register, so the next item is taken while the consumer accepts the current one.
// Depends on nns_pkg, nns_if and nns_divider.
`default_nettype none

module nearest_neighbor_scale_addresser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [nns_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nns_pkg::DIM_W-1:0]     cfg_data,
  nns_in_if.sink                        in_ch,
  nns_out_if.source                     out_ch
);

  typedef enum logic [1:0] {S_IDLE, S_DIV_X, S_DIV_Y, S_EMIT} state_t;

  state_t                      state;
  logic [nns_pkg::DIM_W-1:0]   src_width;
  logic [nns_pkg::DIM_W-1:0]   src_height;
  logic [nns_pkg::DIM_W-1:0]   dst_width;
  logic [nns_pkg::DIM_W-1:0]   dst_height;
  logic [nns_pkg::ACC_W-1:0]   step_x;
  logic [nns_pkg::ACC_W-1:0]   step_y;
  logic [nns_pkg::ACC_W-1:0]   acc_x;
  logic [nns_pkg::ACC_W-1:0]   acc_y;
  logic [nns_pkg::POS_W-1:0]   col_count;
  logic [nns_pkg::POS_W-1:0]   row_count;
  logic                        out_valid;

  nns_pkg::div_req_t           div_req;
  nns_pkg::div_rsp_t           div_rsp;

  logic                        out_free;
  logic                        accept;
  logic                        fire;
  logic                        eol;
  logic                        eof;
  logic [nns_pkg::DIM_W-1:0]   dw;
  logic [nns_pkg::DIM_W-1:0]   dh;

  assign out_free     = ~out_valid | out_ch.ready;
  assign in_ch.ready  = (state == S_IDLE) & out_free;
  assign accept       = in_ch.valid & in_ch.ready;
  assign fire         = (accept & ~in_ch.start_req) | ((state == S_EMIT) & out_free);

  assign dw  = nns_pkg::clamp_dim(dst_width);
  assign dh  = nns_pkg::clamp_dim(dst_height);
  assign eol = ({1'b0, col_count} + nns_pkg::DIM_W'(1)) >= dw;
  assign eof = eol & (({1'b0, row_count} + nns_pkg::DIM_W'(1)) >= dh);

  always_comb begin
    div_req.start = 1'b0;
    div_req.numer = nns_pkg::step_numer(src_width);
    div_req.denom = dw;
    if (state == S_IDLE) begin
      div_req.start = accept & in_ch.start_req;
    end else begin
      div_req.start = (state == S_DIV_X) & div_rsp.done;
      div_req.numer = nns_pkg::step_numer(src_height);
      div_req.denom = dh;
    end
  end

  nns_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      src_width  <= nns_pkg::DIM_W'(1);
      src_height <= nns_pkg::DIM_W'(1);
      dst_width  <= nns_pkg::DIM_W'(1);
      dst_height <= nns_pkg::DIM_W'(1);
      step_x     <= '0;
      step_y     <= '0;
      acc_x      <= '0;
      acc_y      <= '0;
      col_count  <= '0;
      row_count  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          nns_pkg::REG_SRC_WIDTH:  src_width  <= cfg_data;
          nns_pkg::REG_SRC_HEIGHT: src_height <= cfg_data;
          nns_pkg::REG_DST_WIDTH:  dst_width  <= cfg_data;
          nns_pkg::REG_DST_HEIGHT: dst_height <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (accept && in_ch.start_req) begin
            state <= S_DIV_X;
          end
        end
        S_DIV_X: begin
          if (div_rsp.done) begin
            step_x <= div_rsp.quotient;
            state  <= S_DIV_Y;
          end
        end
        S_DIV_Y: begin
          if (div_rsp.done) begin
            step_y    <= div_rsp.quotient;
            acc_x     <= '0;
            acc_y     <= '0;
            col_count <= '0;
            row_count <= '0;
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (fire) begin
        out_valid           <= 1'b1;
        out_ch.src_col      <= acc_x[nns_pkg::FRAC_W +: nns_pkg::POS_W];
        out_ch.src_row      <= acc_y[nns_pkg::FRAC_W +: nns_pkg::POS_W];
        out_ch.dst_col      <= col_count;
        out_ch.dst_row      <= row_count;
        out_ch.end_of_line  <= eol;
        out_ch.end_of_frame <= eof;
        if (eol) begin
          col_count <= '0;
          acc_x     <= '0;
          if (eof) begin
            row_count <= '0;
            acc_y     <= '0;
          end else begin
            row_count <= row_count + nns_pkg::POS_W'(1);
            acc_y     <= acc_y + step_y;
          end
        end else begin
          col_count <= col_count + nns_pkg::POS_W'(1);
          acc_x     <= acc_x + step_x;
        end
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_ch.valid = out_valid;

endmodule

`default_nettype wire

// ===== src/nns_checker.sv =====
// Port-level checks for the nearest-neighbor scale addresser, bound to the top level.
// Depends on nns_pkg for field widths.
`default_nettype none

module nns_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      start_req,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [nns_pkg::POS_W-1:0] src_col,
  input logic [nns_pkg::POS_W-1:0] src_row,
  input logic [nns_pkg::POS_W-1:0] dst_col,
  input logic [nns_pkg::POS_W-1:0] dst_row,
  input logic                      end_of_line,
  input logic                      end_of_frame
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(src_col) && $stable(src_row)
      && $stable(dst_col) && $stable(dst_row) && $stable(end_of_line)
      && $stable(end_of_frame))
    else $error("output beat changed while stalled");

  a_eof_eol: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_frame |-> end_of_line)
    else $error("end_of_frame without end_of_line");

  a_line_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && dst_col == '0 |-> src_col == '0)
    else $error("first column of a line does not map to source column zero");

  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && dst_row == '0 |-> src_row == '0)
    else $error("first row of a frame does not map to source row zero");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && start_req |=> !in_ready)
    else $error("ready during step computation");

endmodule

bind nearest_neighbor_scale_addresser nns_checker u_nns_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .start_req    (in_ch.start_req),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .src_col      (out_ch.src_col),
  .src_row      (out_ch.src_row),
  .dst_col      (out_ch.dst_col),
  .dst_row      (out_ch.dst_row),
  .end_of_line  (out_ch.end_of_line),
  .end_of_frame (out_ch.end_of_frame)
);

`default_nettype wire

// ===== tb/sv/nns_scale_checker.sv =====
// Scoreboard for the nearest-neighbor scale addresser: follows register writes, predicts
// the pixel position of every accepted input beat and compares it with each output beat.
// Depends on nns_pkg and the nns_in_if / nns_out_if stream interfaces.

module nns_scale_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [nns_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nns_pkg::DIM_W-1:0]     cfg_data,
  nns_in_if                             in_mon,
  nns_out_if                            out_mon,
  output int                            mismatches,
  output int                            pending,
  output int                            checked
);

  localparam longint unsigned STEP_UNITY   = 65535;
  localparam int              REPORT_LIMIT = 10;

  typedef struct packed {
    logic [nns_pkg::POS_W-1:0] src_col;
    logic [nns_pkg::POS_W-1:0] src_row;
    logic [nns_pkg::POS_W-1:0] dst_col;
    logic [nns_pkg::POS_W-1:0] dst_row;
    logic                      eol;
    logic                      eof;
  } pixel_pos_t;

  logic [nns_pkg::DIM_W-1:0] src_w, src_h, dst_w, dst_h;
  logic [nns_pkg::ACC_W-1:0] step_x, step_y, acc_x, acc_y;
  logic [nns_pkg::POS_W-1:0] col, row;
  pixel_pos_t                expected_pixels[$];
  int                        fail_count;
  int                        beat_count;

  function automatic int unsigned dim_of(input logic [nns_pkg::DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > nns_pkg::MAX_DIM) return nns_pkg::MAX_DIM;
    return 32'(v);
  endfunction

  function automatic logic [nns_pkg::ACC_W-1:0] scale_step(
      input logic [nns_pkg::DIM_W-1:0] src,
      input logic [nns_pkg::DIM_W-1:0] dst);
    longint unsigned num;
    num = dim_of(src);
    num = num * STEP_UNITY;
    return nns_pkg::ACC_W'(num / dim_of(dst));
  endfunction

  function automatic pixel_pos_t next_position(input logic start);
    pixel_pos_t  p;
    int unsigned dw, dh;
    dw = dim_of(dst_w);
    dh = dim_of(dst_h);
    if (start) begin
      step_x = scale_step(src_w, dst_w);
      step_y = scale_step(src_h, dst_h);
      acc_x  = '0;
      acc_y  = '0;
      col    = '0;
      row    = '0;
    end
    p.eol     = (32'(col) + 1 >= dw);
    p.eof     = p.eol && (32'(row) + 1 >= dh);
    p.src_col = acc_x[nns_pkg::FRAC_W +: nns_pkg::POS_W];
    p.src_row = acc_y[nns_pkg::FRAC_W +: nns_pkg::POS_W];
    p.dst_col = col;
    p.dst_row = row;
    if (p.eol) begin
      col   = '0;
      acc_x = '0;
      if (p.eof) begin
        row   = '0;
        acc_y = '0;
      end else begin
        row   = row + nns_pkg::POS_W'(1);
        acc_y = acc_y + step_y;
      end
    end else begin
      col   = col + nns_pkg::POS_W'(1);
      acc_x = acc_x + step_x;
    end
    return p;
  endfunction

  function automatic string show(input pixel_pos_t p);
    return $sformatf("src(%0d,%0d) dst(%0d,%0d) eol %b eof %b",
                     p.src_col, p.src_row, p.dst_col, p.dst_row, p.eol, p.eof);
  endfunction

  always @(posedge clk) begin
    pixel_pos_t want, got;
    if (rst) begin
      src_w = nns_pkg::DIM_W'(1);
      src_h = nns_pkg::DIM_W'(1);
      dst_w = nns_pkg::DIM_W'(1);
      dst_h = nns_pkg::DIM_W'(1);
      step_x = '0;
      step_y = '0;
      acc_x = '0;
      acc_y = '0;
      col = '0;
      row = '0;
      expected_pixels.delete();
      fail_count = 0;
      beat_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          nns_pkg::REG_SRC_WIDTH:  src_w = cfg_data;
          nns_pkg::REG_SRC_HEIGHT: src_h = cfg_data;
          nns_pkg::REG_DST_WIDTH:  dst_w = cfg_data;
          nns_pkg::REG_DST_HEIGHT: dst_h = cfg_data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_pixels.push_back(next_position(in_mon.start_req));
      end
      if (out_mon.valid && out_mon.ready) begin
        got.src_col = out_mon.src_col;
        got.src_row = out_mon.src_row;
        got.dst_col = out_mon.dst_col;
        got.dst_row = out_mon.dst_row;
        got.eol     = out_mon.end_of_line;
        got.eof     = out_mon.end_of_frame;
        if (expected_pixels.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("unexpected output beat: %s", show(got));
          end
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("beat %0d mismatch: expected %s, got %s",
                       beat_count, show(want), show(got));
            end
          end
        end
        beat_count++;
      end
    end
    mismatches <= fail_count;
    checked    <= beat_count;
    pending    <= expected_pixels.size();
  end

endmodule

// ===== tb/sv/tb_nearest_neighbor_scale_addresser.sv =====
// Top of the scale addresser testbench: drives register writes and input beats with
// random stalls on both streams, and gives the verdict from the scoreboard's counts.
// Depends on nns_pkg, nns_if, nns_scale_checker and the addresser RTL.

module tb_nearest_neighbor_scale_addresser;

  localparam int PHASES      = 10;
  localparam int PHASE_BEATS = 40;

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [nns_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [nns_pkg::DIM_W-1:0]     cfg_data;
  int                            send_idle_pct;
  int                            recv_idle_pct;
  int                            mismatches;
  int                            pending;
  int                            checked;
  int                            starts_sent;
  int                            settings_used;

  nns_in_if  in_ch ();
  nns_out_if out_ch ();

  nearest_neighbor_scale_addresser DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  nns_scale_checker scoreboard (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  initial clk = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(input logic [nns_pkg::CFG_IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= nns_pkg::DIM_W'(value);
    @(posedge clk);
  endtask

  task automatic load_dims(input int sw, input int sh, input int dw, input int dh);
    write_reg(nns_pkg::REG_SRC_WIDTH, sw);
    write_reg(nns_pkg::REG_SRC_HEIGHT, sh);
    write_reg(nns_pkg::REG_DST_WIDTH, dw);
    write_reg(nns_pkg::REG_DST_HEIGHT, dh);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_beat(input logic start);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid     <= 1'b0;
      in_ch.start_req <= 1'($urandom);
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid     <= 1'b1;
    in_ch.start_req <= start;
    do @(posedge clk); while (!in_ch.ready);
    if (start) starts_sent++;
  endtask

  function automatic int pick_dim(input bit wide);
    int r;
    r = $urandom_range(99);
    if (r < 10) return $urandom_range(0, 8191);
    if (r < 15) return nns_pkg::MAX_DIM;
    if (wide) return $urandom_range(1, nns_pkg::MAX_DIM);
    return $urandom_range(1, 9);
  endfunction

  task automatic run_phase(input int beats, input bit pause_midway);
    bit restart;
    restart = $urandom_range(99) < 75;
    for (int i = 0; i < beats; i++) begin
      if (pause_midway && i == beats / 2) drain_results();
      send_beat((i == 0 && restart) || $urandom_range(99) < 8);
    end
  endtask

  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.start_req = 1'b0;
    send_idle_pct   = 33;
    recv_idle_pct   = 77;
    starts_sent     = 0;
    settings_used   = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no start since reset: steps are zero on a 1x1 frame
    repeat (3) send_beat(1'b0);
    drain_results();
    // zero and oversized registers clamp; advance before and after a start
    load_dims(0, 8191, 5, 3);
    repeat (2) send_beat(1'b0);
    send_beat(1'b1);
    repeat (15) send_beat(1'b0);
    drain_results();
    load_dims(4096, 4096, 2, 1);
    send_beat(1'b1);
    repeat (2) send_beat(1'b0);
    drain_results();
    // shrink the frame under a counter that is already past the new width
    load_dims(1, 1, 1, 4096);
    send_beat(1'b0);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      if (ph == 4) begin
        send_idle_pct <= 77;
        recv_idle_pct <= 33;
      end else if (ph == 7) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      case (ph)
        0:       load_dims(4096, 4096, 4096, 4096);
        4:       load_dims(1, 4096, 4096, 1);
        7:       load_dims(4096, 1, 1, 2);
        default: load_dims(pick_dim(1'b1), pick_dim(1'b1), pick_dim(1'b0), pick_dim(1'b0));
      endcase
      run_phase(PHASE_BEATS, ph == 2);
    end

    drain_results();
    repeat (64) @(posedge clk);
    $display("Checked %0d pixel positions from %0d frame starts over %0d register settings",
             checked, starts_sent, settings_used);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
